/* rtl/core/spst_pkg.sv */
// Package for the memory pattern self-test core: field widths, codes,
// register reset values and the data background function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spst_pkg;

  // Default size of the memory under test, in bytes
  localparam int unsigned MemoryBytesDefault = 1048576;

  // Fixed field widths
  localparam int unsigned TestBytesW = 24;
  localparam int unsigned WordW      = 16;
  localparam int unsigned MemIndexW  = 19;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned TestedW    = 21;
  localparam int unsigned DefBytesW  = 21;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned PhaseW     = 3;

  // Register reset values
  localparam logic [DefBytesW-1:0] DefBytesReset = 21'd65536;
  localparam logic [AddrW-1:0]     BaseAddrReset = 32'h6000_0000;

  // Five passes: address-xor background, then four solid backgrounds
  localparam logic [PhaseW-1:0] NumPhases   = 3'd5;
  localparam logic [WordW-1:0]  AddrPattern = 16'hA5A5;

  typedef enum logic {
    ActStart = 1'b0,
    ActStep  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    MemNone  = 2'd0,
    MemWrite = 2'd1,
    MemRead  = 2'd2
  } mem_req_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StFail = 2'd1,
    StBusy = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDefaultBytes = 1'b0,
    CfgBaseAddr     = 1'b1
  } cfg_idx_e;

  // Data background of a pass at a given halfword index
  function automatic logic [WordW-1:0] pattern_of(input logic [PhaseW-1:0] phase,
                                                   input logic [WordW-1:0]  idx);
    logic [WordW-1:0] pat;
    case (phase[1:0] - 2'd1)
      2'd0:    pat = 16'h0000;
      2'd1:    pat = 16'hFFFF;
      2'd2:    pat = 16'hAAAA;
      default: pat = 16'h5555;
    endcase
    if (phase == '0) begin
      pat = AddrPattern ^ idx;
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/spst_if.sv */
// Channel interfaces of the memory pattern self-test core: the item input
// and the result output. Depend on spst_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spst_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [spst_pkg::TestBytesW-1:0]   test_bytes;
  logic [spst_pkg::WordW-1:0]        read_data;

  modport source (output valid, action, test_bytes, read_data, input ready);
  modport sink   (input valid, action, test_bytes, read_data, output ready);
endinterface

interface spst_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mem_request;
  logic [spst_pkg::MemIndexW-1:0]    mem_index;
  logic [spst_pkg::WordW-1:0]        mem_write_data;
  logic                              start_rejected;
  logic [1:0]                        test_status;
  logic [spst_pkg::AddrW-1:0]        fail_address;
  logic [spst_pkg::WordW-1:0]        expected_value;
  logic [spst_pkg::WordW-1:0]        actual_value;
  logic [spst_pkg::CountW-1:0]       pass_count;
  logic [spst_pkg::CountW-1:0]       fail_count;
  logic [spst_pkg::TestedW-1:0]      tested_bytes;

  modport source (output valid, mem_request, mem_index, mem_write_data, start_rejected,
                  test_status, fail_address, expected_value, actual_value, pass_count,
                  fail_count, tested_bytes, input ready);
  modport sink   (input valid, mem_request, mem_index, mem_write_data, start_rejected,
                  test_status, fail_address, expected_value, actual_value, pass_count,
                  fail_count, tested_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/spst_size.sv */
// Test size decode: default substitution, clamp to the memory size and
// rounding to whole halfwords. Depends on spst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spst_size #(
  parameter int unsigned MemoryBytes = spst_pkg::MemoryBytesDefault
) (
  input  wire logic [spst_pkg::TestBytesW-1:0]        test_bytes_i,
  input  wire logic [spst_pkg::DefBytesW-1:0]         default_bytes_i,
  output logic      [$clog2(MemoryBytes + 1)-1:0]     bytes_o,
  output logic                                        reject_o
);
  import spst_pkg::*;

  localparam int unsigned CntW = $clog2(MemoryBytes + 1);

  logic [31:0] sel_bytes;
  logic [31:0] clamp_bytes;
  logic [31:0] even_bytes;

  // Zero asks for the default; clamp; drop an odd trailing byte
  always_comb begin
    sel_bytes   = (test_bytes_i == '0) ? 32'(default_bytes_i) : 32'(test_bytes_i);
    clamp_bytes = (sel_bytes > 32'(MemoryBytes)) ? 32'(MemoryBytes) : sel_bytes;
    even_bytes  = clamp_bytes & ~32'd1;
  end

  assign bytes_o  = even_bytes[CntW-1:0];
  assign reject_o = (even_bytes == '0);

endmodule

`default_nettype wire

/* rtl/core/sram_pattern_self_test_core.sv */
// Top level of the memory pattern self-test core: test sequencer, failure
// record, counters and result register. Depends on spst_pkg, spst_if, spst_size.
`timescale 1ns / 1ps
`default_nettype none

// Memory data-background self-test sequencer. Every accepted item (a start or a
// memory step) yields one registered result, holding the next memory command
// and the status after that item. One item is taken per cycle: the sequencer
// state updates at the transfer and the single result register is refilled in the
// same cycle that the downstream side takes its content, so the only stall is
// back-pressure on the output channel. Step items must return the read data for
// the read issued by the previous item. Configuration writes are taken at any
// time and should be made while no test is running.
module sram_pattern_self_test_core #(
  parameter int unsigned MemoryBytes = spst_pkg::MemoryBytesDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  spst_in_if.sink                               in_ch,
  spst_out_if.source                            out_ch,
  input  wire logic                             cfg_we_i,
  input  wire logic [spst_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [spst_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import spst_pkg::*;

  localparam int unsigned CntW = $clog2(MemoryBytes + 1);
  localparam int unsigned HwW  = $clog2(MemoryBytes / 2 + 1);

  // Configuration registers
  logic [DefBytesW-1:0] def_bytes_q;
  logic [AddrW-1:0]     base_addr_q;

  // Sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              reading_q, reading_d;
  logic [HwW-1:0]    cursor_q, cursor_d;
  logic [HwW-1:0]    total_q, total_d;
  status_e           status_q, status_d;
  logic [AddrW-1:0]  fail_addr_q, fail_addr_d;
  logic [WordW-1:0]  exp_q, exp_d;
  logic [WordW-1:0]  act_q, act_d;
  logic [CountW-1:0] passes_q, passes_d;
  logic [CountW-1:0] fails_q, fails_d;
  logic [CntW-1:0]   tested_q, tested_d;
  logic              pend_valid_q, pend_valid_d;
  logic [HwW-1:0]    pend_idx_q, pend_idx_d;
  logic [WordW-1:0]  pend_exp_q, pend_exp_d;

  // Result register (command part)
  logic              out_valid_q;
  mem_req_e          req_q, req_d;
  logic [MemIndexW-1:0] idx_q, idx_d;
  logic [WordW-1:0]  wdata_q, wdata_d;
  logic              rej_q, rej_d;

  // Working values
  logic              in_xfer;
  logic [CntW-1:0]   start_bytes;
  logic              start_reject;
  logic              do_issue;
  logic [PhaseW-1:0] phase_b;
  logic              reading_b;
  logic [HwW-1:0]    cursor_b;
  logic [HwW:0]      cursor_inc;
  logic [31:0]       cursor_wide;
  logic [WordW-1:0]  pattern;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Start size decode
  spst_size #(
    .MemoryBytes (MemoryBytes)
  ) u_size (
    .test_bytes_i    (in_ch.test_bytes),
    .default_bytes_i (def_bytes_q),
    .bytes_o         (start_bytes),
    .reject_o        (start_reject)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_bytes_q <= DefBytesReset;
      base_addr_q <= BaseAddrReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDefaultBytes: def_bytes_q <= cfg_wdata_i[DefBytesW-1:0];
        CfgBaseAddr:     base_addr_q <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Item processing: start/step decode, read-back compare, next command
  always_comb begin
    phase_d      = phase_q;
    reading_d    = reading_q;
    cursor_d     = cursor_q;
    total_d      = total_q;
    status_d     = status_q;
    fail_addr_d  = fail_addr_q;
    exp_d        = exp_q;
    act_d        = act_q;
    passes_d     = passes_q;
    fails_d      = fails_q;
    tested_d     = tested_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_exp_d   = pend_exp_q;
    req_d        = MemNone;
    idx_d        = '0;
    wdata_d      = '0;
    rej_d        = 1'b0;
    do_issue     = 1'b0;
    phase_b      = phase_q;
    reading_b    = reading_q;
    cursor_b     = cursor_q;

    if (in_xfer) begin
      if (action_e'(in_ch.action) == ActStart) begin
        if (start_reject) begin
          rej_d = 1'b1;
        end else begin
          tested_d     = start_bytes;
          total_d      = start_bytes[CntW-1:1];
          fail_addr_d  = '0;
          exp_d        = '0;
          act_d        = '0;
          status_d     = StBusy;
          phase_b      = '0;
          reading_b    = 1'b0;
          cursor_b     = '0;
          pend_valid_d = 1'b0;
          do_issue     = 1'b1;
        end
      end else if (status_q == StBusy) begin
        pend_valid_d = 1'b0;
        if (pend_valid_q && (in_ch.read_data != pend_exp_q)) begin
          // First mismatch ends the test
          fail_addr_d = base_addr_q + (32'(pend_idx_q) << 1);
          exp_d       = pend_exp_q;
          act_d       = in_ch.read_data;
          status_d    = StFail;
          fails_d     = fails_q + 1'b1;
        end else if (phase_q >= NumPhases) begin
          status_d = StOk;
          passes_d = passes_q + 1'b1;
        end else begin
          do_issue = 1'b1;
        end
      end
    end

    // Command at the cursor, then advance cursor / half / pass
    cursor_wide = 32'(cursor_b);
    pattern     = pattern_of(phase_b, cursor_wide[WordW-1:0]);
    cursor_inc  = {1'b0, cursor_b} + 1'b1;
    if (do_issue) begin
      idx_d = cursor_wide[MemIndexW-1:0];
      if (!reading_b) begin
        req_d   = MemWrite;
        wdata_d = pattern;
      end else begin
        req_d        = MemRead;
        pend_valid_d = 1'b1;
        pend_idx_d   = cursor_b;
        pend_exp_d   = pattern;
      end
      phase_d   = phase_b;
      reading_d = reading_b;
      cursor_d  = cursor_inc[HwW-1:0];
      if (cursor_inc >= {1'b0, total_d}) begin
        cursor_d = '0;
        if (!reading_b) begin
          reading_d = 1'b1;
        end else begin
          reading_d = 1'b0;
          phase_d   = phase_b + 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      reading_q    <= 1'b0;
      cursor_q     <= '0;
      total_q      <= '0;
      status_q     <= StOk;
      fail_addr_q  <= '0;
      exp_q        <= '0;
      act_q        <= '0;
      passes_q     <= '0;
      fails_q      <= '0;
      tested_q     <= '0;
      pend_valid_q <= 1'b0;
      pend_idx_q   <= '0;
      pend_exp_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      reading_q    <= reading_d;
      cursor_q     <= cursor_d;
      total_q      <= total_d;
      status_q     <= status_d;
      fail_addr_q  <= fail_addr_d;
      exp_q        <= exp_d;
      act_q        <= act_d;
      passes_q     <= passes_d;
      fails_q      <= fails_d;
      tested_q     <= tested_d;
      pend_valid_q <= pend_valid_d;
      pend_idx_q   <= pend_idx_d;
      pend_exp_q   <= pend_exp_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command part of the result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= req_d;
      idx_q   <= idx_d;
      wdata_q <= wdata_d;
      rej_q   <= rej_d;
    end
  end

  // Status fields come straight from state, which only moves on a transfer
  logic [31:0] tested_wide;
  assign tested_wide = 32'(tested_q);

  assign out_ch.valid          = out_valid_q;
  assign out_ch.mem_request    = req_q;
  assign out_ch.mem_index      = idx_q;
  assign out_ch.mem_write_data = wdata_q;
  assign out_ch.start_rejected = rej_q;
  assign out_ch.test_status    = status_q;
  assign out_ch.fail_address   = fail_addr_q;
  assign out_ch.expected_value = exp_q;
  assign out_ch.actual_value   = act_q;
  assign out_ch.pass_count     = passes_q;
  assign out_ch.fail_count     = fails_q;
  assign out_ch.tested_bytes   = tested_wide[TestedW-1:0];

`ifndef SYNTHESIS
  // A running test always has halfwords to cover
  a_busy_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q == StBusy) |-> (total_q != '0))
    else $error("busy with an empty test size");

  // The pass index never runs beyond the pass count
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= NumPhases)
    else $error("pass index out of range");

  // A memory command in a result only while the test is running
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (req_q != MemNone)) |-> (status_q == StBusy))
    else $error("memory command issued outside a running test");

  // A rejected start leaves the running status alone
  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_ch.action == ActStart) && start_reject) |=> $stable(status_q))
    else $error("rejected start changed the test status");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the memory pattern self-test core: random and directed
// starts and memory steps, results checked against an in-bench sequencer model.
// Depends on spst_pkg, spst_if and sram_pattern_self_test_core.
`timescale 1ns / 1ps

module tb_top;
  import spst_pkg::*;

  // One input item as queued for the driver
  typedef struct {
    action_e          act;
    logic [23:0]      bytes;
    logic [15:0]      rd;
  } test_item_t;

  // One result as the core reports it
  typedef struct packed {
    mem_req_e         mem_request;
    logic [18:0]      mem_index;
    logic [15:0]      mem_write_data;
    logic             start_rejected;
    status_e          test_status;
    logic [31:0]      fail_address;
    logic [15:0]      expected_value;
    logic [15:0]      actual_value;
    logic [31:0]      pass_count;
    logic [31:0]      fail_count;
    logic [20:0]      tested_bytes;
  } seq_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_index_i;
  logic [31:0] cfg_wdata_i;

  spst_in_if  in_ch ();
  spst_out_if out_ch ();

  sram_pattern_self_test_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  test_item_t  test_items[$];
  seq_report_t sequencer_reports[$];
  test_item_t  next_item;
  seq_report_t seen_want;
  int          queued_items  = 0;
  int          results_seen  = 0;
  int          hold_left     = 0;
  int          mismatches    = 0;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 78;

  // Sequencer model state
  logic [20:0] m_default    = DefBytesReset;
  logic [31:0] m_base       = BaseAddrReset;
  logic [2:0]  m_phase      = '0;
  logic        m_reading    = 1'b0;
  logic [18:0] m_cursor     = '0;
  logic [19:0] m_total      = '0;
  status_e     m_status     = StOk;
  logic [31:0] m_fail_addr  = '0;
  logic [15:0] m_exp        = '0;
  logic [15:0] m_act        = '0;
  logic [31:0] m_passes     = '0;
  logic [31:0] m_fails      = '0;
  logic [20:0] m_tested     = '0;
  logic        m_pend_valid = 1'b0;
  logic [18:0] m_pend_index = '0;
  logic [15:0] m_pend_exp   = '0;

  // Data background written in a given pass at a given halfword
  function automatic logic [15:0] background(input logic [2:0] phase, input logic [18:0] idx);
    case (phase)
      3'd0:    return AddrPattern ^ idx[15:0];
      3'd1:    return 16'h0000;
      3'd2:    return 16'hFFFF;
      3'd3:    return 16'hAAAA;
      default: return 16'h5555;
    endcase
  endfunction

  // Requested count after default, clamp to memory size and rounding to even
  function automatic logic [20:0] clamp_bytes(input logic [23:0] req, input logic [20:0] dflt);
    logic [23:0] b;
    b = (req == '0) ? 24'(dflt) : req;
    if (b > 24'(MemoryBytesDefault)) b = 24'(MemoryBytesDefault);
    b[0] = 1'b0;
    return b[20:0];
  endfunction

  // Advance the sequencer model by one item and queue the result it owes
  function automatic void sequencer_step(input action_e act, input logic [23:0] req,
                                         input logic [15:0] rd);
    seq_report_t r;
    logic [20:0] bytes;
    logic        issue;
    logic        failed;
    r      = '0;
    issue  = 1'b0;
    failed = 1'b0;
    if (act == ActStart) begin
      bytes = clamp_bytes(req, m_default);
      if (bytes == '0) begin
        r.start_rejected = 1'b1;
      end else begin
        m_tested     = bytes;
        m_total      = 20'(bytes >> 1);
        m_fail_addr  = '0;
        m_exp        = '0;
        m_act        = '0;
        m_status     = StBusy;
        m_phase      = '0;
        m_reading    = 1'b0;
        m_cursor     = '0;
        m_pend_valid = 1'b0;
        issue        = 1'b1;
      end
    end else if (m_status == StBusy) begin
      // compare the read issued by the previous item
      if (m_pend_valid) begin
        m_pend_valid = 1'b0;
        if (rd != m_pend_exp) begin
          m_fail_addr = m_base + {12'd0, m_pend_index, 1'b0};
          m_exp       = m_pend_exp;
          m_act       = rd;
          m_status    = StFail;
          m_fails     = m_fails + 32'd1;
          failed      = 1'b1;
        end
      end
      if (!failed) begin
        if (m_phase >= NumPhases) begin
          m_status = StOk;
          m_passes = m_passes + 32'd1;
        end else begin
          issue = 1'b1;
        end
      end
    end
    // memory command at the cursor, then step through the pass
    if (issue) begin
      r.mem_index = m_cursor;
      if (!m_reading) begin
        r.mem_request    = MemWrite;
        r.mem_write_data = background(m_phase, m_cursor);
      end else begin
        r.mem_request = MemRead;
        m_pend_valid  = 1'b1;
        m_pend_index  = m_cursor;
        m_pend_exp    = background(m_phase, m_cursor);
      end
      if (20'(m_cursor) + 20'd1 >= m_total) begin
        m_cursor = '0;
        if (!m_reading) begin
          m_reading = 1'b1;
        end else begin
          m_reading = 1'b0;
          m_phase   = m_phase + 3'd1;
        end
      end else begin
        m_cursor = m_cursor + 19'd1;
      end
    end
    r.test_status    = m_status;
    r.fail_address   = m_fail_addr;
    r.expected_value = m_exp;
    r.actual_value   = m_act;
    r.pass_count     = m_passes;
    r.fail_count     = m_fails;
    r.tested_bytes   = m_tested;
    sequencer_reports.push_back(r);
  endfunction

  function automatic int field_differs(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic void push_item(input action_e act, input logic [23:0] bytes,
                                    input logic [15:0] rd);
    test_items.push_back('{act, bytes, rd});
    queued_items++;
  endfunction

  // A start and up to max_steps well-formed steps; a rejected start goes in before
  // step reject_at, and a readback at step bad_step is corrupted and ends the session
  task automatic queue_session(input logic [23:0] req, input int max_steps,
                               input int bad_step, input int reject_at);
    int          n_half;
    int          total;
    int          m;
    logic [15:0] rd;
    n_half = int'(clamp_bytes(req, m_default) >> 1);
    push_item(ActStart, req, 16'($urandom));
    if (n_half == 0) return;
    total = 10 * n_half;
    if (max_steps < total) total = max_steps;
    for (int j = 1; j <= total; j++) begin
      if (j == reject_at) push_item(ActStart, 24'd1, 16'($urandom));
      m  = j - 1;
      rd = 16'($urandom);
      if ((m % (2 * n_half)) >= n_half) begin
        rd = background(3'(m / (2 * n_half)), 19'((m % (2 * n_half)) - n_half));
        if (j == bad_step) begin
          push_item(ActStep, 24'($urandom), rd ^ 16'($urandom_range(1, 16'hFFFF)));
          return;
        end
      end
      push_item(ActStep, 24'($urandom), rd);
    end
  endtask

  // Mostly complete small tests, some with a bad readback, plus abandoned
  // large tests, stray steps and rejected starts
  task automatic queue_random(input int target);
    int          pick;
    int          first;
    logic [23:0] req;
    first = queued_items;
    while (queued_items - first < target) begin
      pick = $urandom_range(0, 99);
      if (m_default >= 2 && m_default <= 34 && $urandom_range(0, 2) == 0) req = '0;
      else req = 24'($urandom_range(2, 17));
      if (pick < 55) begin
        queue_session(req, 1 << 30, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0);
      end else if (pick < 75) begin
        queue_session(req, 1 << 30, $urandom_range(2, 80), 0);
      end else if (pick < 85) begin
        queue_session(($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom),
                      $urandom_range(0, 30), 0, 0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(ActStep, 24'($urandom), 16'($urandom));
          queued_items--;
        end
      end else begin
        push_item(ActStart, (m_default < 2 && $urandom_range(0, 1) == 1) ? 24'd0 : 24'd1,
                  16'($urandom));
      end
    end
    // leave the core out of a running test
    queue_session(24'd2, 10, 2, 0);
  endtask

  // Sender pause: nothing offered until every result is in
  task automatic wait_idle();
    do @(negedge clk_i);
    while (test_items.size() != 0 || in_ch.valid || sequencer_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CfgDefaultBytes) m_default = value[20:0];
    else m_base = value;
  endtask

  // Driver: model the item at its transfer, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sequencer_step(action_e'(in_ch.action), in_ch.test_bytes, in_ch.read_data);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (test_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item         = test_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= next_item.act;
          in_ch.test_bytes <= next_item.bytes;
          in_ch.read_data  <= next_item.rd;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, with two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (sequencer_reports.size() == 0) begin
          $display("%0t: result expected none actual status %0h", $time, out_ch.test_status);
          mismatches++;
        end else begin
          seen_want = sequencer_reports.pop_front();
          mismatches += field_differs("mem_request", seen_want.mem_request,
                                      out_ch.mem_request);
          mismatches += field_differs("mem_index", seen_want.mem_index, out_ch.mem_index);
          mismatches += field_differs("mem_write_data", seen_want.mem_write_data,
                                      out_ch.mem_write_data);
          mismatches += field_differs("start_rejected", seen_want.start_rejected,
                                      out_ch.start_rejected);
          mismatches += field_differs("test_status", seen_want.test_status,
                                      out_ch.test_status);
          mismatches += field_differs("fail_address", seen_want.fail_address,
                                      out_ch.fail_address);
          mismatches += field_differs("expected_value", seen_want.expected_value,
                                      out_ch.expected_value);
          mismatches += field_differs("actual_value", seen_want.actual_value,
                                      out_ch.actual_value);
          mismatches += field_differs("pass_count", seen_want.pass_count, out_ch.pass_count);
          mismatches += field_differs("fail_count", seen_want.fail_count, out_ch.fail_count);
          mismatches += field_differs("tested_bytes", seen_want.tested_bytes,
                                      out_ch.tested_bytes);
        end
        if (results_seen == 200 || results_seen == 700) hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus and phase sequencing
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = ActStart;
    in_ch.test_bytes = '0;
    in_ch.read_data  = '0;
    out_ch.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CfgDefaultBytes;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset register values
    push_item(ActStep, 24'hFFFFFF, 16'hFFFF);     // step with no test running
    push_item(ActStart, 24'd1, 16'h0000);         // rounds down to zero bytes
    queue_session(24'd0, 1, 0, 0);                // default size, then abandoned
    queue_session(24'd3, 10, 0, 1);               // one halfword to a pass, rejected start inside
    push_item(ActStep, 24'd0, 16'h0000);          // step after a pass
    queue_session(24'd4, 10, 3, 0);               // mismatch on the first readback
    queue_session(24'hFFFFFF, 2, 0, 0);           // clamped to the memory size
    queue_session(24'd2, 10, 2, 0);
    wait_idle();

    write_register(CfgDefaultBytes, 32'd0);
    write_register(CfgBaseAddr, 32'hFFFF_FFFF);
    queue_random(210);
    wait_idle();

    send_idle_pct = 78;
    recv_idle_pct = 34;
    write_register(CfgDefaultBytes, 32'd6);
    write_register(CfgBaseAddr, $urandom);
    queue_random(210);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CfgDefaultBytes, 32'h1F_FFFF);
    write_register(CfgBaseAddr, 32'd0);
    queue_random(110);
    wait_idle();
    queue_random(110);
    wait_idle();

    write_register(CfgDefaultBytes, 32'd1);
    write_register(CfgBaseAddr, $urandom);
    queue_random(40);
    wait_idle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/spst_pkg.sv
rtl/core/spst_if.sv
rtl/core/spst_size.sv
rtl/core/sram_pattern_self_test_core.sv
bench/tb_top.sv
